// ===== hdl/button_debounce_tap_hold_defines.svh =====
// Assertion macros used by the debouncer's slot module.
`ifndef BUTTON_DEBOUNCE_TAP_HOLD_DEFINES_SVH
`define BUTTON_DEBOUNCE_TAP_HOLD_DEFINES_SVH

`ifndef SYNTHESIS
// Checks a property on every rising clock edge outside reset.
`define BDTH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
// Checks that a condition implies a consequence in the same cycle.
`define BDTH_ASSERT_IMPL(lbl, ante, cons) \
  `BDTH_ASSERT(lbl, (ante) |-> (cons))
`else
`define BDTH_ASSERT(lbl, prop)
`define BDTH_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

// ===== hdl/bdth_pkg.sv =====
// Types and constants of the two-button tap/hold debouncer.
package bdth_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned MsW = 16;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes.
  localparam logic [CfgAddrW-1:0] CfgDebounce = 3'd0;
  localparam logic [CfgAddrW-1:0] CfgLongPress = 3'd1;
  localparam logic [CfgAddrW-1:0] CfgEnableA = 3'd2;
  localparam logic [CfgAddrW-1:0] CfgEnableB = 3'd3;
  localparam logic [CfgAddrW-1:0] CfgHoldEnable = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [MsW-1:0] DebounceReset = 16'd30;
  localparam logic [MsW-1:0] LongPressReset = 16'd2000;
  localparam logic EnableAReset = 1'b1;
  localparam logic EnableBReset = 1'b0;
  localparam logic HoldEnableReset = 1'b1;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             down_a;
    logic             down_b;
  } item_t;

  typedef struct packed {
    logic pressed_a;
    logic pressed_b;
    logic any_pressed;
    logic tap_a;
    logic tap_b;
    logic hold_a;
    logic hold_b;
  } result_t;

  typedef struct packed {
    logic [MsW-1:0] settle_ms;
    logic [MsW-1:0] hold_time_ms;
    logic           enable_a;
    logic           enable_b;
    logic           hold_enable;
  } cfg_t;

  // Per-button outcome of one poll tick.
  typedef struct packed {
    logic pressed;
    logic tap;
    logic hold;
  } slot_res_t;

endpackage

// ===== hdl/bdth_cfg.sv =====
// Configuration register file of the debouncer.
module bdth_cfg
  import bdth_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgDebounce:   cfg_d.settle_ms = cfg_wdata_i[MsW-1:0];
        CfgLongPress:  cfg_d.hold_time_ms = cfg_wdata_i[MsW-1:0];
        CfgEnableA:    cfg_d.enable_a = cfg_wdata_i[0];
        CfgEnableB:    cfg_d.enable_b = cfg_wdata_i[0];
        CfgHoldEnable: cfg_d.hold_enable = cfg_wdata_i[0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_ms <= DebounceReset;
      cfg_q.hold_time_ms <= LongPressReset;
      cfg_q.enable_a <= EnableAReset;
      cfg_q.enable_b <= EnableBReset;
      cfg_q.hold_enable <= HoldEnableReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/bdth_slot.sv =====
// Debounce and tap/hold classification state of one button.
`include "button_debounce_tap_hold_defines.svh"

module bdth_slot
  import bdth_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [TimeW-1:0] now_i,
  input  logic             down_i,
  input  logic [MsW-1:0]   settle_ms_i,
  input  logic [MsW-1:0]   hold_time_ms_i,
  input  logic             hold_enable_i,
  output slot_res_t        res_o
);

  logic             raw_q, stable_q, hold_done_q;
  logic [TimeW-1:0] change_time_q, press_time_q;

  logic             raw_change, debounce_ok, press_acc, release_acc;
  logic             stable_next, hold_done_base, hold_fire;
  logic [TimeW-1:0] since_change, since_press;

  assign raw_change   = down_i != raw_q;
  assign since_change = now_i - change_time_q;
  assign debounce_ok  = !raw_change && (down_i != stable_q) &&
                        (since_change >= {{(TimeW-MsW){1'b0}}, settle_ms_i});
  assign press_acc    = debounce_ok && down_i;
  assign release_acc  = debounce_ok && !down_i;
  assign stable_next  = debounce_ok ? down_i : stable_q;

  // A press accepted on this tick starts its hold time at zero.
  assign hold_done_base = press_acc ? 1'b0 : hold_done_q;
  assign since_press    = press_acc ? '0 : (now_i - press_time_q);
  assign hold_fire      = hold_enable_i && stable_next && !hold_done_base &&
                          (since_press >= {{(TimeW-MsW){1'b0}}, hold_time_ms_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q <= 1'b0;
      stable_q <= 1'b0;
      hold_done_q <= 1'b0;
      change_time_q <= '0;
      press_time_q <= '0;
    end else if (step_i) begin
      if (raw_change) begin
        raw_q <= down_i;
        change_time_q <= now_i;
      end
      if (press_acc) begin
        press_time_q <= now_i;
      end
      stable_q <= stable_next;
      hold_done_q <= hold_done_base || hold_fire;
    end
  end

  always_comb begin
    res_o.pressed = step_i ? stable_next : stable_q;
    res_o.tap = step_i && release_acc && !hold_done_q;
    res_o.hold = step_i && hold_fire;
  end

  `BDTH_ASSERT_IMPL(tap_hold_exclusive_a, res_o.tap, !res_o.hold)
  `BDTH_ASSERT(hold_marks_done_a, res_o.hold |=> hold_done_q)
  `BDTH_ASSERT(idle_keeps_state_a, !step_i |=> $stable(stable_q) && $stable(raw_q))
  `BDTH_ASSERT(tap_only_on_release_a, res_o.tap |=> !stable_q)

endmodule

// ===== hdl/button_debounce_tap_hold.sv =====
// Two-button debouncer with tap and hold pulses, one poll tick per transaction.
// A tick is held in the input register, then its result in the output register.
// Throughput: one tick per cycle unless the output stalls; each is a compare-and-update pass of each enabled button.
// Reset: asynchronous, active low; clears all button state, loads configuration defaults
// (debounce 30 ms, long press 2000 ms, primary enabled, secondary disabled, hold on).
module button_debounce_tap_hold
  import bdth_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  item_t               in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output result_t             out_result_o,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t      cfg;
  item_t     item_q;
  result_t   result_d, result_q;
  slot_res_t res_a, res_b;
  logic      item_valid_q, out_valid_q, advance;

  bdth_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The input stage moves on whenever the result register is free or being emptied.
  assign advance    = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        item_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  bdth_slot u_slot_a (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance && cfg.enable_a),
    .now_i           (item_q.now_ms),
    .down_i          (item_q.down_a),
    .settle_ms_i     (cfg.settle_ms),
    .hold_time_ms_i  (cfg.hold_time_ms),
    .hold_enable_i   (cfg.hold_enable),
    .res_o           (res_a)
  );

  bdth_slot u_slot_b (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance && cfg.enable_b),
    .now_i           (item_q.now_ms),
    .down_i          (item_q.down_b),
    .settle_ms_i     (cfg.settle_ms),
    .hold_time_ms_i  (cfg.hold_time_ms),
    .hold_enable_i   (cfg.hold_enable),
    .res_o           (res_b)
  );

  always_comb begin
    result_d.pressed_a = res_a.pressed;
    result_d.pressed_b = res_b.pressed;
    result_d.any_pressed = res_a.pressed || res_b.pressed;
    result_d.tap_a = res_a.tap;
    result_d.tap_b = res_b.tap;
    result_d.hold_a = res_a.hold;
    result_d.hold_b = res_b.hold;
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = result_q;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the two-button tap/hold debouncer.
`timescale 1ns / 1ps

module tb_top;
  import bdth_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned BacklogCycles = 400;

  typedef struct {
    logic             raw;
    logic [TimeW-1:0] change_ms;
    logic [TimeW-1:0] press_ms;
    logic             stable;
    logic             hold_done;
  } button_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                tick_valid = 1'b0;
  logic                tick_ready;
  item_t               tick_item = '0;
  logic                status_valid;
  logic                status_ready = 1'b0;
  result_t             status;
  logic                cfg_we = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  // Predictor copy of the configuration and of both buttons.
  logic [MsW-1:0] mdl_debounce = DebounceReset;
  logic [MsW-1:0] mdl_long_press = LongPressReset;
  logic           mdl_en_a = EnableAReset;
  logic           mdl_en_b = EnableBReset;
  logic           mdl_hold_en = HoldEnableReset;
  button_t        btn_a = '{raw: 1'b0, change_ms: '0, press_ms: '0, stable: 1'b0,
                            hold_done: 1'b0};
  button_t        btn_b = '{raw: 1'b0, change_ms: '0, press_ms: '0, stable: 1'b0,
                            hold_done: 1'b0};

  item_t       poll_q[$];
  result_t     predicted_q[$];
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned statuses_seen = 0;
  logic        tick_taken = 1'b0;
  logic        status_taken = 1'b0;
  logic        no_idle = 1'b0;
  int unsigned tick_gap = 0;
  int unsigned stall_left = 0;
  logic        backlog_done = 1'b0;

  // Stimulus generator state.
  logic [TimeW-1:0] t_now = '0;
  logic             lvl_a = 1'b0;
  logic             lvl_b = 1'b0;

  button_debounce_tap_hold u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (tick_valid),
    .in_ready_o  (tick_ready),
    .in_item_i   (tick_item),
    .out_valid_o (status_valid),
    .out_ready_i (status_ready),
    .out_result_o(status),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned next_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic void update_button(inout button_t b, input logic down,
                                        input logic [TimeW-1:0] now,
                                        output logic tap, output logic hold);
    logic [TimeW-1:0] since_change;
    logic [TimeW-1:0] since_press;
    tap = 1'b0;
    hold = 1'b0;
    since_change = now - b.change_ms;
    // A raw change only restarts the debounce time; nothing is accepted on that tick.
    if (down != b.raw) begin
      b.raw = down;
      b.change_ms = now;
    end else if (down != b.stable && since_change >= 32'(mdl_debounce)) begin
      b.stable = down;
      if (down) begin
        b.press_ms = now;
        b.hold_done = 1'b0;
      end else if (!b.hold_done) begin
        tap = 1'b1;
      end
    end
    // The hold check sees the debounced state of this same tick.
    since_press = now - b.press_ms;
    if (mdl_hold_en && b.stable && !b.hold_done && since_press >= 32'(mdl_long_press)) begin
      b.hold_done = 1'b1;
      hold = 1'b1;
    end
  endfunction

  function automatic result_t debounce_tick(item_t tick);
    result_t r;
    logic    tap_a, hold_a, tap_b, hold_b;
    r = '0;
    tap_a = 1'b0;
    hold_a = 1'b0;
    tap_b = 1'b0;
    hold_b = 1'b0;
    if (mdl_en_a) update_button(btn_a, tick.down_a, tick.now_ms, tap_a, hold_a);
    if (mdl_en_b) update_button(btn_b, tick.down_b, tick.now_ms, tap_b, hold_b);
    r.pressed_a = btn_a.stable;
    r.pressed_b = btn_b.stable;
    r.any_pressed = btn_a.stable | btn_b.stable;
    r.tap_a = tap_a;
    r.tap_b = tap_b;
    r.hold_a = hold_a;
    r.hold_b = hold_b;
    return r;
  endfunction

  task automatic report_field(string name, logic exp_v, logic got_v);
    if (got_v !== exp_v) begin
      fail_cnt++;
      $display("%0t: %s mismatch, expected %b, actual %b", $time, name, exp_v, got_v);
    end
  endtask

  // Sampling, configuration tracking, checking and prediction at the rising edge.
  always @(posedge clk_i) begin
    result_t want;
    tick_taken = tick_valid && tick_ready;
    status_taken = status_valid && status_ready;
    if (rst_ni) begin
      if (cfg_we) begin
        case (cfg_addr)
          CfgDebounce:   mdl_debounce = cfg_wdata[MsW-1:0];
          CfgLongPress:  mdl_long_press = cfg_wdata[MsW-1:0];
          CfgEnableA:    mdl_en_a = cfg_wdata[0];
          CfgEnableB:    mdl_en_b = cfg_wdata[0];
          CfgHoldEnable: mdl_hold_en = cfg_wdata[0];
          default: ;
        endcase
      end
      if (status_taken) begin
        statuses_seen++;
        if (predicted_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected transaction, expected none, actual %b", $time, status);
        end else begin
          want = predicted_q.pop_front();
          report_field("pressed_a", want.pressed_a, status.pressed_a);
          report_field("pressed_b", want.pressed_b, status.pressed_b);
          report_field("any_pressed", want.any_pressed, status.any_pressed);
          report_field("tap_a", want.tap_a, status.tap_a);
          report_field("tap_b", want.tap_b, status.tap_b);
          report_field("hold_a", want.hold_a, status.hold_a);
          report_field("hold_b", want.hold_b, status.hold_b);
        end
      end
      if (tick_taken) predicted_q.push_back(debounce_tick(tick_item));
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Sender: offers queued poll ticks with random gaps after each transaction.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      tick_valid <= 1'b0;
      tick_gap <= 0;
    end else if (!tick_valid || tick_taken) begin
      if (tick_gap != 0) begin
        tick_valid <= 1'b0;
        tick_gap <= tick_gap - 1;
      end else if (poll_q.size() != 0) begin
        tick_item <= poll_q.pop_front();
        tick_valid <= 1'b1;
        tick_gap <= next_gap();
      end else begin
        tick_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off while the sender still has work.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      status_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      status_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!backlog_done && statuses_seen >= 600 && poll_q.size() > 50) begin
      backlog_done <= 1'b1;
      stall_left <= BacklogCycles;
      status_ready <= 1'b0;
    end else begin
      status_ready <= 1'b1;
      if (status_taken) stall_left <= next_gap();
    end
  end

  task automatic push_tick(logic [TimeW-1:0] now, logic da, logic db);
    item_t it;
    it.now_ms = now;
    it.down_a = da;
    it.down_b = db;
    poll_q.push_back(it);
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (poll_q.size() != 0 || tick_valid || predicted_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
  endtask

  // Mostly clean press/release episodes, with some contact bounce and time jumps.
  task automatic gen_ticks(int unsigned n, int unsigned step_max, int unsigned toggle_pct);
    logic sa, sb;
    repeat (n) begin
      if ($urandom_range(0, 99) < 2) begin
        t_now = $urandom;
      end else begin
        t_now = t_now + $urandom_range(0, step_max);
      end
      if ($urandom_range(0, 99) < toggle_pct) lvl_a = ~lvl_a;
      if ($urandom_range(0, 99) < toggle_pct) lvl_b = ~lvl_b;
      sa = lvl_a ^ ($urandom_range(0, 99) < 5);
      sb = lvl_b ^ ($urandom_range(0, 99) < 5);
      push_tick(t_now, sa, sb);
    end
  endtask

  task automatic run_phase(logic [CfgDataW-1:0] deb, logic [CfgDataW-1:0] long_ms,
                           logic [CfgDataW-1:0] en_a, logic [CfgDataW-1:0] en_b,
                           logic [CfgDataW-1:0] hold_en, logic burst,
                           int unsigned n, int unsigned step_max,
                           int unsigned toggle_pct);
    wait_idle();
    write_reg(CfgDebounce, deb);
    write_reg(CfgLongPress, long_ms);
    write_reg(CfgEnableA, en_a);
    write_reg(CfgEnableB, en_b);
    write_reg(CfgHoldEnable, hold_en);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    no_idle = burst;
    if ($urandom_range(0, 3) == 0) t_now = 32'hFFFF_FFFF - $urandom_range(0, 3000);
    gen_ticks(n, step_max, toggle_pct);
  endtask

  initial begin
    logic [CfgDataW-1:0] deb;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset configuration: primary button only, 30 ms debounce, 2000 ms hold.
    push_tick(32'd0, 1'b0, 1'b0);
    push_tick(32'd0, 1'b1, 1'b1);
    push_tick(32'd29, 1'b1, 1'b0);
    push_tick(32'd30, 1'b1, 1'b1);
    push_tick(32'd2029, 1'b1, 1'b0);
    push_tick(32'd2030, 1'b1, 1'b1);
    push_tick(32'd2100, 1'b0, 1'b0);
    push_tick(32'd2130, 1'b0, 1'b0);
    push_tick(32'd2200, 1'b1, 1'b0);
    push_tick(32'd2230, 1'b1, 1'b0);
    push_tick(32'd2240, 1'b0, 1'b1);
    push_tick(32'd2250, 1'b1, 1'b0);
    push_tick(32'd2300, 1'b0, 1'b0);
    push_tick(32'd2330, 1'b0, 1'b0);
    // Debounce and hold measured across the timestamp wrap.
    push_tick(32'hFFFF_FFF0, 1'b1, 1'b1);
    push_tick(32'h0000_000D, 1'b1, 1'b1);
    push_tick(32'h0000_000E, 1'b1, 1'b0);
    push_tick(32'h0000_07DD, 1'b1, 1'b0);
    push_tick(32'h0000_07DE, 1'b1, 1'b1);
    push_tick(32'hFFFF_FFFF, 1'b0, 1'b1);
    push_tick(32'hAAAA_5555, 1'b0, 1'b0);
    push_tick(32'h5555_AAAA, 1'b0, 1'b0);

    // Zero debounce and zero long-press time, both buttons.
    run_phase(16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 1'b0, 120, 3, 10);
    // Hold detection off: every clean release taps. Upper data bits are ignored.
    run_phase(16'd5, 16'd40, 16'hFFFF, 16'hFFFF, 16'hFFFE, 1'b0, 120, 4, 8);
    // Largest times with the primary button disabled.
    run_phase(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001, 16'h0001, 1'b0, 100, 25000, 10);
    // Secondary disabled: its debounced state must stay where it was left.
    run_phase(16'd0, 16'hFFFF, 16'd1, 16'hFFF0, 16'd1, 1'b1, 60, 3, 10);

    for (int i = 0; i < 10; i++) begin
      deb = 16'($urandom_range(0, 60));
      run_phase(deb, 16'($urandom_range(0, 400)), 16'($urandom), 16'($urandom),
                16'($urandom), (i == 3) || ($urandom_range(0, 99) < 15), 105,
                32'(deb) / 3 + 3, $urandom_range(3, 12));
    end

    wait_idle();
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
